/* design/osrc_pkg.sv */
`default_nettype none

package osrc_pkg;

  // Field widths
  localparam int unsigned RAW_W  = 10;
  localparam int unsigned TEMP_W = 8;
  localparam int unsigned LAM_W  = 15;
  localparam int unsigned DAC_W  = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_BAND   = 2'd1
  } cfg_idx_e;

  localparam logic [CFG_DATA_W-1:0] TARGET_RESET = 8'd237;
  localparam logic [CFG_DATA_W-1:0] BAND_RESET   = 8'd5;

  // Lambda curve: 12 points, 11 segments; y rises along the curve
  localparam int unsigned NUM_PTS = 12;
  localparam int unsigned NUM_SEG = NUM_PTS - 1;
  localparam int unsigned SEG_W   = $clog2(NUM_SEG);
  localparam int unsigned DY_W    = 13;  // largest rise is 4200
  localparam int unsigned DX_W    = 9;   // widest span is 340
  localparam int unsigned PROD_W  = 17;  // largest rise*span is 109200

  localparam logic [RAW_W-1:0] CURVE_X [NUM_PTS] = '{
    10'd200, 10'd260, 10'd600, 10'd621, 10'd642, 10'd663,
    10'd684, 10'd702, 10'd726, 10'd747, 10'd760, 10'd799
  };

  localparam logic [LAM_W-1:0] CURVE_Y [NUM_PTS] = '{
    15'd0,     15'd68,    15'd150,   15'd200,   15'd2500,  15'd5000,
    15'd7500,  15'd11000, 15'd13500, 15'd16000, 15'd20200, 15'd23000
  };

  localparam logic [DY_W-1:0] SEG_DY [NUM_SEG] = '{
    13'd68,   13'd82,   13'd50,   13'd2300, 13'd2500, 13'd2500,
    13'd3500, 13'd2500, 13'd2500, 13'd4200, 13'd2800
  };

  // Exact floor(prod/span) for prod < 2^PROD_W: ceil(2^SHIFT/span), SHIFT = PROD_W + 9
  localparam int unsigned DIV_SHIFT = 26;
  localparam int unsigned RECIP_W   = 23;

  localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEG] = '{
    23'((64'd67108864 + 64'd59)  / 64'd60),
    23'((64'd67108864 + 64'd339) / 64'd340),
    23'((64'd67108864 + 64'd20)  / 64'd21),
    23'((64'd67108864 + 64'd20)  / 64'd21),
    23'((64'd67108864 + 64'd20)  / 64'd21),
    23'((64'd67108864 + 64'd20)  / 64'd21),
    23'((64'd67108864 + 64'd17)  / 64'd18),
    23'((64'd67108864 + 64'd23)  / 64'd24),
    23'((64'd67108864 + 64'd20)  / 64'd21),
    23'((64'd67108864 + 64'd12)  / 64'd13),
    23'((64'd67108864 + 64'd38)  / 64'd39)
  };

  // DAC: floor(lam*13/1000) as lam * (13*ceil(2^29/1000)) >> 29, exact for lam*13 < 2^19
  localparam int unsigned DAC_MUL_W = 23;
  localparam int unsigned DAC_SHIFT = 29;
  localparam logic [DAC_MUL_W-1:0] DAC_MUL =
    23'(64'd13 * ((64'd536870912 + 64'd999) / 64'd1000));
  localparam int unsigned DAC_Q_W = 9;   // quotient up to 299
  localparam logic [DAC_W-1:0] DAC_MAX = 8'd255;

endpackage

`default_nettype wire

/* design/oxygen_sensor_reading_convert.sv */
`default_nettype none

// Channel  Ports                                                      Handshake
// -------  ---------------------------------------------------------  -----------------------
// input    pump_average_i, nernst_plain_i, nernst_with_dc_i           start & !busy
// config   cfg_index_i, cfg_data_i                                    cfg_we_i, no wait
// result   temperature_o, temp_in_band_o, lambda_value_o, dac_code_o  done_o strobe, no stall
//
// One word in per cycle; busy is tied low, so every start is taken.
// From start to done each step is registered: segment search, rise*dx multiply,
// reciprocal multiply for the span divide, base add, DAC scaling multiply.
// The 17x23 reciprocal and 15x23 DAC multiplies set the cycle time.
// Reset clears the valid chain and loads target 237, half width 5.
// The receiver cannot stall, so nothing ever waits inside the pipe.
module oxygen_sensor_reading_convert (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [osrc_pkg::RAW_W-1:0]          pump_average_i,
  input  wire logic [osrc_pkg::RAW_W-1:0]          nernst_plain_i,
  input  wire logic [osrc_pkg::RAW_W-1:0]          nernst_with_dc_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [osrc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [osrc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                     done_o,
  output logic [osrc_pkg::TEMP_W-1:0]              temperature_o,
  output logic                                     temp_in_band_o,
  output logic [osrc_pkg::LAM_W-1:0]               lambda_value_o,
  output logic [osrc_pkg::DAC_W-1:0]               dac_code_o
);

  // seg (1) + interp (3) + dac (1)
  localparam int unsigned DEPTH = 5;

  logic [osrc_pkg::CFG_DATA_W-1:0]  target_q, band_q;

  logic                             in_valid;
  logic [osrc_pkg::RAW_W:0]         diff;
  logic [osrc_pkg::TEMP_W-1:0]      temp_d;
  logic [osrc_pkg::TEMP_W+1:0]      temp_ext, tgt_ext, hw_ext;
  logic                             in_band_d;

  logic [osrc_pkg::TEMP_W-1:0]      temp_q [DEPTH];
  logic                             in_band_q [DEPTH];

  logic                             seg_valid, interp_valid, dac_valid;
  logic [osrc_pkg::SEG_W-1:0]       seg;
  logic [osrc_pkg::DX_W-1:0]        dx;
  logic [osrc_pkg::LAM_W-1:0]       lam_interp, lam_out;
  logic [osrc_pkg::DAC_W-1:0]       dac_out;

  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  // Config registers; an index past the list is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= osrc_pkg::TARGET_RESET;
      band_q   <= osrc_pkg::BAND_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        osrc_pkg::CFG_TARGET: target_q <= cfg_data_i;
        osrc_pkg::CFG_BAND:   band_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Heater temperature: 255 - (with_dc - plain), 0 on wrap or overflow.
  // Band test: target - hw < temp < target + hw, written without subtraction
  // so nothing wraps.
  always_comb begin
    diff = {1'b0, nernst_with_dc_i} - {1'b0, nernst_plain_i};
    if (diff[osrc_pkg::RAW_W:osrc_pkg::TEMP_W] == '0) begin
      temp_d = ~diff[osrc_pkg::TEMP_W-1:0];
    end else begin
      temp_d = '0;
    end
    temp_ext  = {2'b00, temp_d};
    tgt_ext   = {2'b00, target_q};
    hw_ext    = {2'b00, band_q};
    in_band_d = ((temp_ext + hw_ext) > tgt_ext) && (temp_ext < (tgt_ext + hw_ext));
  end

  // temperature words ride alongside the lambda pipe
  always_ff @(posedge clk_i) begin
    temp_q[0]    <= temp_d;
    in_band_q[0] <= in_band_d;
    for (int i = 1; i < DEPTH; i++) begin
      temp_q[i]    <= temp_q[i-1];
      in_band_q[i] <= in_band_q[i-1];
    end
  end

  osrc_seg u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .pump_i  (pump_average_i),
    .valid_o (seg_valid),
    .seg_o   (seg),
    .dx_o    (dx)
  );

  osrc_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (seg_valid),
    .seg_i   (seg),
    .dx_i    (dx),
    .valid_o (interp_valid),
    .lam_o   (lam_interp)
  );

  osrc_dac u_dac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (interp_valid),
    .lam_i   (lam_interp),
    .valid_o (dac_valid),
    .lam_o   (lam_out),
    .dac_o   (dac_out)
  );

  assign done_o         = dac_valid;
  assign temperature_o  = temp_q[DEPTH-1];
  assign temp_in_band_o = in_band_q[DEPTH-1];
  assign lambda_value_o = lam_out;
  assign dac_code_o     = dac_out;

  // 19616 is the smallest lambda with lambda*13/1000 >= 255
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((lambda_value_o >= 15'd19616) == (dac_code_o == osrc_pkg::DAC_MAX)))
    else $error("top: dac saturation out of step with lambda");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (lambda_value_o == '0) |-> dac_code_o == '0)
    else $error("top: nonzero dac for zero lambda");

endmodule

`default_nettype wire

/* design/osrc_seg.sv */
`default_nettype none

// Segment search: picks the curve segment and offset for a pump reading.
module osrc_seg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [osrc_pkg::RAW_W-1:0]      pump_i,
  output logic                                 valid_o,
  output logic [osrc_pkg::SEG_W-1:0]           seg_o,
  output logic [osrc_pkg::DX_W-1:0]            dx_o
);

  logic                         valid_q;
  logic [osrc_pkg::SEG_W-1:0]   seg_d, seg_q;
  logic [osrc_pkg::DX_W-1:0]    dx_d, dx_q;
  logic [osrc_pkg::RAW_W-1:0]   off;

  always_comb begin
    seg_d = '0;
    for (int i = 1; i < osrc_pkg::NUM_SEG; i++) begin
      if (pump_i >= osrc_pkg::CURVE_X[i]) begin
        seg_d = osrc_pkg::SEG_W'(i);
      end
    end
    off = pump_i - osrc_pkg::CURVE_X[seg_d];
    if (pump_i < osrc_pkg::CURVE_X[0]) begin
      dx_d = '0;
    end else if (pump_i > osrc_pkg::CURVE_X[osrc_pkg::NUM_PTS-1]) begin
      // past the end: full last span lands exactly on the last y
      dx_d = osrc_pkg::DX_W'(osrc_pkg::CURVE_X[osrc_pkg::NUM_PTS-1]
                             - osrc_pkg::CURVE_X[osrc_pkg::NUM_SEG-1]);
    end else begin
      dx_d = off[osrc_pkg::DX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    dx_q  <= dx_d;
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;
  assign dx_o    = dx_q;

endmodule

`default_nettype wire

/* design/osrc_interp.sv */
`default_nettype none

// Three stages: rise*dx, divide by span via reciprocal, add segment base.
module osrc_interp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [osrc_pkg::SEG_W-1:0]      seg_i,
  input  wire logic [osrc_pkg::DX_W-1:0]       dx_i,
  output logic                                 valid_o,
  output logic [osrc_pkg::LAM_W-1:0]           lam_o
);

  localparam int unsigned MUL1_W = osrc_pkg::DY_W + osrc_pkg::DX_W;
  localparam int unsigned MUL2_W = osrc_pkg::PROD_W + osrc_pkg::RECIP_W;

  logic [2:0]                    valid_q;
  logic [MUL1_W-1:0]             mul1;
  logic [MUL2_W-1:0]             mul2;

  logic [osrc_pkg::PROD_W-1:0]   prod_d, prod_q;
  logic [osrc_pkg::SEG_W-1:0]    seg_a_q;
  logic [osrc_pkg::DY_W-1:0]     quo_d, quo_q;
  logic [osrc_pkg::LAM_W-1:0]    base_a_q, base_b_q;
  logic [osrc_pkg::DY_W-1:0]     rise_a_q, rise_b_q;
  logic [osrc_pkg::LAM_W-1:0]    lam_d, lam_q;

  always_comb begin
    mul1   = MUL1_W'(osrc_pkg::SEG_DY[seg_i]) * MUL1_W'(dx_i);
    prod_d = mul1[osrc_pkg::PROD_W-1:0];
    mul2   = MUL2_W'(prod_q) * MUL2_W'(osrc_pkg::SEG_RECIP[seg_a_q]);
    quo_d  = mul2[osrc_pkg::DIV_SHIFT +: osrc_pkg::DY_W];
    lam_d  = base_b_q + osrc_pkg::LAM_W'(quo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    seg_a_q  <= seg_i;
    base_a_q <= osrc_pkg::CURVE_Y[seg_i];
    rise_a_q <= osrc_pkg::SEG_DY[seg_i];
    quo_q    <= quo_d;
    base_b_q <= base_a_q;
    rise_b_q <= rise_a_q;
    lam_q    <= lam_d;
  end

  assign valid_o = valid_q[2];
  assign lam_o   = lam_q;

  // quotient never passes the segment rise (dx <= span)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> quo_q <= rise_b_q)
    else $error("interp: quotient above segment rise");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> lam_q <= osrc_pkg::CURVE_Y[osrc_pkg::NUM_PTS-1])
    else $error("interp: lambda above curve end");

endmodule

`default_nettype wire

/* design/osrc_dac.sv */
`default_nettype none

// DAC code stage: constant multiply for /1000 scaling, then saturate.
module osrc_dac (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [osrc_pkg::LAM_W-1:0]      lam_i,
  output logic                                 valid_o,
  output logic [osrc_pkg::LAM_W-1:0]           lam_o,
  output logic [osrc_pkg::DAC_W-1:0]           dac_o
);

  localparam int unsigned MUL_W = osrc_pkg::LAM_W + osrc_pkg::DAC_MUL_W;

  logic                             valid_q;
  logic [MUL_W-1:0]                 mul;
  logic [osrc_pkg::DAC_Q_W-1:0]     quo;
  logic [osrc_pkg::DAC_W-1:0]       dac_d, dac_q;
  logic [osrc_pkg::LAM_W-1:0]       lam_q;

  always_comb begin
    mul = MUL_W'(lam_i) * MUL_W'(osrc_pkg::DAC_MUL);
    quo = mul[osrc_pkg::DAC_SHIFT +: osrc_pkg::DAC_Q_W];
    if (quo > osrc_pkg::DAC_Q_W'(osrc_pkg::DAC_MAX)) begin
      dac_d = osrc_pkg::DAC_MAX;
    end else begin
      dac_d = quo[osrc_pkg::DAC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dac_q <= dac_d;
    lam_q <= lam_i;
  end

  assign valid_o = valid_q;
  assign lam_o   = lam_q;
  assign dac_o   = dac_q;

endmodule

`default_nettype wire
